### design/char_lcd_8bit_interface_sequencer_assert.svh
// assertion macros used by the sequencer top-level design file
`ifndef CHAR_LCD_8BIT_INTERFACE_SEQUENCER_ASSERT_SVH
`define CHAR_LCD_8BIT_INTERFACE_SEQUENCER_ASSERT_SVH

// same-cycle implication, off during reset
`define LCDSEQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define LCDSEQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

// condition that must hold in the cycle after reset is applied
`define LCDSEQ_ASSERT_RST(lbl, clk, rst_n, cons, msg) \
  lbl: assert property (@(posedge clk) (!(rst_n)) |=> (cons)) else $error(msg);

`endif

### design/lcdseq_pkg.sv
`timescale 1ns / 1ps
package lcdseq_pkg;

  localparam int CFG_W = 17;
  localparam int CFG_IDX_W = 3;
  localparam int TICK_COUNT_WIDTH_DEF = 17;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_POWERUP_WAIT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CMD_PULSE    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CHAR_PULSE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_GAP    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SHORT_GAP    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_GAP     = 3'd5;

  localparam logic [CFG_W-1:0] POWERUP_WAIT_DEF = 17'd110000;
  localparam logic [CFG_W-1:0] CMD_PULSE_DEF    = 17'd4000;
  localparam logic [CFG_W-1:0] CHAR_PULSE_DEF   = 17'd40;
  localparam logic [CFG_W-1:0] FIRST_GAP_DEF    = 17'd5000;
  localparam logic [CFG_W-1:0] SHORT_GAP_DEF    = 17'd20;
  localparam logic [CFG_W-1:0] STEP_GAP_DEF     = 17'd55;

  // request types
  localparam logic [2:0] REQ_TICK    = 3'd0;
  localparam logic [2:0] REQ_CMD     = 3'd1;
  localparam logic [2:0] REQ_CHAR    = 3'd2;
  localparam logic [2:0] REQ_CURSOR  = 3'd3;
  localparam logic [2:0] REQ_RESTART = 3'd4;

  localparam logic [7:0] ROW1 = 8'd1;
  localparam logic [7:0] ROW2 = 8'd2;
  localparam logic [7:0] ROW1_BASE = 8'h80;
  localparam logic [7:0] ROW2_BASE = 8'hC0;

  typedef struct packed {
    logic [2:0] req_type;
    logic [7:0] byte_value;
    logic [7:0] column;
  } in_item_t;

  typedef struct packed {
    logic       rs_pin;
    logic       en_pin;
    logic [7:0] data_pins;
    logic       busy_res;
    logic       rejected;
  } out_item_t;

  typedef struct packed {
    logic [CFG_W-1:0] powerup_wait_ticks;
    logic [CFG_W-1:0] command_pulse_ticks;
    logic [CFG_W-1:0] char_pulse_ticks;
    logic [CFG_W-1:0] first_gap_ticks;
    logic [CFG_W-1:0] short_gap_ticks;
    logic [CFG_W-1:0] step_gap_ticks;
  } cfg_regs_t;

  // power-up command sequence
  function automatic logic [7:0] init_cmd(input logic [2:0] step);
    logic [7:0] c;
    unique case (step)
      3'd0, 3'd1, 3'd2: c = 8'h30;
      3'd3:             c = 8'h38;
      3'd4:             c = 8'h08;
      3'd5:             c = 8'h01;
      3'd6:             c = 8'h06;
      default:          c = 8'h0C;
    endcase
    return c;
  endfunction

endpackage

### design/lcdseq_cfg.sv
`timescale 1ns / 1ps
module lcdseq_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [lcdseq_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lcdseq_pkg::CFG_W-1:0]     cfg_wdata,
  output lcdseq_pkg::cfg_regs_t            cfg
);
  import lcdseq_pkg::*;

  cfg_regs_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.powerup_wait_ticks  <= POWERUP_WAIT_DEF;
      cfg_r.command_pulse_ticks <= CMD_PULSE_DEF;
      cfg_r.char_pulse_ticks    <= CHAR_PULSE_DEF;
      cfg_r.first_gap_ticks     <= FIRST_GAP_DEF;
      cfg_r.short_gap_ticks     <= SHORT_GAP_DEF;
      cfg_r.step_gap_ticks      <= STEP_GAP_DEF;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_POWERUP_WAIT: cfg_r.powerup_wait_ticks  <= cfg_wdata;
        CFG_CMD_PULSE:    cfg_r.command_pulse_ticks <= cfg_wdata;
        CFG_CHAR_PULSE:   cfg_r.char_pulse_ticks    <= cfg_wdata;
        CFG_FIRST_GAP:    cfg_r.first_gap_ticks     <= cfg_wdata;
        CFG_SHORT_GAP:    cfg_r.short_gap_ticks     <= cfg_wdata;
        CFG_STEP_GAP:     cfg_r.step_gap_ticks      <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

### design/lcdseq_core.sv
`timescale 1ns / 1ps
module lcdseq_core #(
  parameter int TICK_COUNT_WIDTH = lcdseq_pkg::TICK_COUNT_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step_en,
  input  lcdseq_pkg::in_item_t  item,
  input  lcdseq_pkg::cfg_regs_t cfg,
  output lcdseq_pkg::out_item_t res
);
  import lcdseq_pkg::*;

  localparam logic [1:0] PH_IDLE    = 2'd0;
  localparam logic [1:0] PH_POWERUP = 2'd1;
  localparam logic [1:0] PH_PULSE   = 2'd2;
  localparam logic [1:0] PH_GAP     = 2'd3;

  localparam logic [32:0] CNT_MAX = (33'd1 << TICK_COUNT_WIDTH) - 33'd1;

  typedef logic [TICK_COUNT_WIDTH-1:0] cnt_t;

  // loads saturate at the counter's full scale
  function automatic cnt_t sat_cnt(input logic [CFG_W-1:0] v);
    logic [32:0] wide;
    wide = 33'(v);
    if (wide > CNT_MAX) return '1;
    return wide[TICK_COUNT_WIDTH-1:0];
  endfunction

  logic [1:0] phase_r, phase_nxt;
  logic [3:0] step_r, step_nxt;
  cnt_t       cnt_r, cnt_nxt;
  logic       in_init_r, in_init_nxt;
  logic       rs_r, rs_nxt;
  logic       en_r, en_nxt;
  logic [7:0] data_r, data_nxt;

  logic             busy;
  logic             rej;
  cnt_t             cnt_dec;
  cnt_t             cmd_len;
  cnt_t             char_len;
  cnt_t             gap_cnt;
  logic [CFG_W-1:0] gap_sel;
  logic [3:0]       step_inc;

  always_comb begin
    busy     = phase_r != PH_IDLE;
    cnt_dec  = (cnt_r != '0) ? cnt_r - cnt_t'(1) : cnt_r;
    cmd_len  = (cfg.command_pulse_ticks == '0) ? cnt_t'(1) : sat_cnt(cfg.command_pulse_ticks);
    char_len = (cfg.char_pulse_ticks == '0) ? cnt_t'(1) : sat_cnt(cfg.char_pulse_ticks);
    step_inc = step_r + 4'd1;
    priority if (step_r == 4'd0)  gap_sel = cfg.first_gap_ticks;
    else if (step_r <= 4'd2)      gap_sel = cfg.short_gap_ticks;
    else if (step_r <= 4'd5)      gap_sel = cfg.step_gap_ticks;
    else                          gap_sel = '0;
    gap_cnt = sat_cnt(gap_sel);

    phase_nxt   = phase_r;
    step_nxt    = step_r;
    cnt_nxt     = cnt_r;
    in_init_nxt = in_init_r;
    rs_nxt      = rs_r;
    en_nxt      = en_r;
    data_nxt    = data_r;
    rej         = 1'b0;

    unique case (item.req_type)
      REQ_TICK: begin
        if (busy) begin
          cnt_nxt = cnt_dec;
          if (cnt_dec == '0) begin
            unique case (phase_r)
              PH_POWERUP: begin
                step_nxt  = 4'd0;
                rs_nxt    = 1'b0;
                en_nxt    = 1'b1;
                data_nxt  = init_cmd(3'd0);
                phase_nxt = PH_PULSE;
                cnt_nxt   = cmd_len;
              end
              PH_PULSE: begin
                en_nxt = 1'b0;
                if (!in_init_r) begin
                  phase_nxt = PH_IDLE;
                end else if (gap_cnt != '0) begin
                  phase_nxt = PH_GAP;
                  cnt_nxt   = gap_cnt;
                end else if (step_inc[3]) begin
                  // zero gap after the last command: init done at once
                  step_nxt    = step_inc;
                  phase_nxt   = PH_IDLE;
                  in_init_nxt = 1'b0;
                  cnt_nxt     = gap_cnt;
                end else begin
                  step_nxt  = step_inc;
                  en_nxt    = 1'b1;
                  rs_nxt    = 1'b0;
                  data_nxt  = init_cmd(step_inc[2:0]);
                  phase_nxt = PH_PULSE;
                  cnt_nxt   = cmd_len;
                end
              end
              PH_GAP: begin
                step_nxt = step_inc;
                if (step_inc[3]) begin
                  phase_nxt   = PH_IDLE;
                  in_init_nxt = 1'b0;
                end else begin
                  en_nxt    = 1'b1;
                  rs_nxt    = 1'b0;
                  data_nxt  = init_cmd(step_inc[2:0]);
                  phase_nxt = PH_PULSE;
                  cnt_nxt   = cmd_len;
                end
              end
              PH_IDLE: ;
            endcase
          end
        end
      end
      REQ_CMD: begin
        if (busy) begin
          rej = 1'b1;
        end else begin
          rs_nxt    = 1'b0;
          en_nxt    = 1'b1;
          data_nxt  = item.byte_value;
          phase_nxt = PH_PULSE;
          cnt_nxt   = cmd_len;
        end
      end
      REQ_CHAR: begin
        if (busy) begin
          rej = 1'b1;
        end else begin
          rs_nxt    = 1'b1;
          en_nxt    = 1'b1;
          data_nxt  = item.byte_value;
          phase_nxt = PH_PULSE;
          cnt_nxt   = char_len;
        end
      end
      REQ_CURSOR: begin
        if (busy) begin
          rej = 1'b1;
        end else if (item.byte_value == ROW1 || item.byte_value == ROW2) begin
          rs_nxt    = 1'b0;
          en_nxt    = 1'b1;
          data_nxt  = (item.byte_value == ROW1) ? ROW1_BASE + item.column - 8'd1
                                                : ROW2_BASE + item.column - 8'd1;
          phase_nxt = PH_PULSE;
          cnt_nxt   = cmd_len;
        end
      end
      REQ_RESTART: begin
        phase_nxt   = PH_POWERUP;
        step_nxt    = 4'd0;
        in_init_nxt = 1'b1;
        rs_nxt      = 1'b0;
        en_nxt      = 1'b0;
        data_nxt    = 8'h00;
        cnt_nxt     = sat_cnt(cfg.powerup_wait_ticks);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_POWERUP;
      step_r    <= 4'd0;
      cnt_r     <= sat_cnt(POWERUP_WAIT_DEF);
      in_init_r <= 1'b1;
      rs_r      <= 1'b0;
      en_r      <= 1'b0;
      data_r    <= 8'h00;
    end else if (step_en) begin
      phase_r   <= phase_nxt;
      step_r    <= step_nxt;
      cnt_r     <= cnt_nxt;
      in_init_r <= in_init_nxt;
      rs_r      <= rs_nxt;
      en_r      <= en_nxt;
      data_r    <= data_nxt;
    end
  end

  assign res.rs_pin    = rs_nxt;
  assign res.en_pin    = en_nxt;
  assign res.data_pins = data_nxt;
  assign res.busy_res  = phase_nxt != PH_IDLE;
  assign res.rejected  = rej;

endmodule

### design/char_lcd_8bit_interface_sequencer.sv
`timescale 1ns / 1ps
// Sequencer for an 8-bit parallel character display bus (RS, EN, D0..D7).
// Input channel in_valid/in_ready/in_item: each item is a one-microsecond
// tick, a command byte, a character, a cursor move or a restart of init.
// Output channel out_valid/out_ready/out_item: exactly one result per item,
// giving the pin levels after that item plus busy and rejected flags.
// Configuration: cfg_we with cfg_index/cfg_wdata writes one timing register
// in the same cycle; write only while no items are in flight.
// Path: an accepted item waits in the input register; its result is then
// captured in the result register and shown at out_item.
// Throughput: one item per cycle while out_ready keeps the output draining;
// the pin/timer update is a single pass of logic between the two registers.
// Reset (rst_n low, synchronous) clears both stages, loads the default
// timings and starts the power-up wait with all pins low.
// When out_ready is low the result register holds; the input register still
// takes one more item, after which in_ready drops until the output drains.
module char_lcd_8bit_interface_sequencer #(
  parameter int TICK_COUNT_WIDTH = lcdseq_pkg::TICK_COUNT_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  lcdseq_pkg::in_item_t             in_item,
  output logic                             out_valid,
  input  logic                             out_ready,
  output lcdseq_pkg::out_item_t            out_item,
  input  logic                             cfg_we,
  input  logic [lcdseq_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lcdseq_pkg::CFG_W-1:0]     cfg_wdata
);
  import lcdseq_pkg::*;

  `include "char_lcd_8bit_interface_sequencer_assert.svh"

  logic      in_vld_r;
  in_item_t  in_item_r;
  logic      out_vld_r;
  out_item_t out_item_r;
  logic      advance;
  cfg_regs_t cfg;
  out_item_t res;

  // item moves from the input register into the result register
  assign advance  = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || advance;

  lcdseq_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  lcdseq_core #(
    .TICK_COUNT_WIDTH (TICK_COUNT_WIDTH)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (advance),
    .item    (in_item_r),
    .cfg     (cfg),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_ready) begin
        in_vld_r <= in_valid;
      end
      if (advance) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_item_r <= in_item;
    end
    if (advance) begin
      out_item_r <= res;
    end
  end

  assign out_valid = out_vld_r;
  assign out_item  = out_item_r;

  `LCDSEQ_ASSERT_IMP(a_rej_busy, clk, rst_n, out_vld_r && out_item_r.rejected,
    out_item_r.busy_res, "rejected result without busy")
  `LCDSEQ_ASSERT_IMP(a_en_busy, clk, rst_n, out_vld_r && out_item_r.en_pin,
    out_item_r.busy_res, "enable high while sequencer idle")
  `LCDSEQ_ASSERT_NXT(a_adv_lands, clk, rst_n, advance, out_vld_r,
    "advanced item missing from result register")
  `LCDSEQ_ASSERT_NXT(a_in_hold, clk, rst_n, in_vld_r && !advance, in_vld_r,
    "held item lost from input register")
  `LCDSEQ_ASSERT_RST(a_rst_empty, clk, rst_n, !in_vld_r && !out_vld_r,
    "pipeline not empty after reset")

endmodule
